@@ rtl/xml_tag_stream_tokenizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// xml_tag_stream_tokenizer_core_defines
// assertion macro for the xml tag tokenizer
// ----------------------------------------------------------------------------
`ifndef XML_TAG_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define XML_TAG_STREAM_TOKENIZER_CORE_DEFINES_SVH
// property must hold whenever out of reset
`define XTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`endif

@@ rtl/xtt_pkg.sv @@
// ----------------------------------------------------------------------------
// xtt_pkg
// types and codes shared by the xml tag tokenizer modules
// ----------------------------------------------------------------------------
package xtt_pkg;
  typedef enum logic [1:0] {MODE_CONTENT = 2'd0, MODE_TAG = 2'd1, MODE_HALT = 2'd2} mode_e;
  typedef enum logic [3:0] {
    G_LEAD = 4'd0, G_SLASH_SP = 4'd1, G_NAME = 4'd2, G_ENAME = 4'd3, G_END_TAIL = 4'd4,
    G_ATTR_SEP = 4'd5, G_ANAME = 4'd6, G_AEQ = 4'd7, G_AVAL_SP = 4'd8, G_AVAL = 4'd9,
    G_SLASH_TAIL = 4'd10, G_IGNORE = 4'd11, G_ERROR = 4'd12
  } gram_e;
  localparam logic [3:0] K_CONTENT = 4'd0;
  localparam logic [3:0] K_ELEM    = 4'd1;
  localparam logic [3:0] K_ATTR    = 4'd2;
  localparam logic [3:0] K_VALUE   = 4'd3;
  localparam logic [3:0] K_START   = 4'd4;
  localparam logic [3:0] K_END     = 4'd5;
  localparam logic [3:0] K_EMPTY   = 4'd6;
  localparam logic [3:0] K_IGNORED = 4'd7;
  localparam logic [3:0] K_ERROR   = 4'd8;
  localparam logic [3:0] K_DOC_OK  = 4'd9;
  // one classified word: up to two events
  typedef struct packed {
    logic       v0;
    logic [3:0] k0;
    logic       v1;
    logic [3:0] k1;
  } evt_t;
endpackage

@@ rtl/xtt_front.sv @@
// ----------------------------------------------------------------------------
// xtt_front
// byte scanner: mode, quote and tag grammar tracking, when take_i is high one byte per cycle
// ----------------------------------------------------------------------------
module xtt_front #(
  parameter int MAX_ATTRS   = 256,
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  output xtt_pkg::evt_t evt_o,
  output logic          evt_v_o
);
  import xtt_pkg::*;
  localparam int AW = $clog2(MAX_ATTRS + 1);

  mode_e mode_q, mode_d;
  gram_e gs_q, gs_d;
  logic [7:0] oq_q, oq_d, vq_q, vq_d;
  logic [2:0] tl_q, tl_d;
  logic [23:0] head_q, head_d;
  logic [15:0] prev_q, prev_d;
  logic [AW-1:0] ac_q, ac_d;
  logic cs_q, cs_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  logic sp, qt, may_close, tb;
  logic [3:0] k, ck;
  logic kv;
  evt_t e;

  always_comb begin
    sp = (data_i == 8'd32) || (data_i >= 8'd9 && data_i <= 8'd13);
    qt = (data_i == 8'h22) || (data_i == 8'h27);
    may_close = 1'b1;
    if (oq_q != 8'd0) may_close = 1'b0;
    else if (tl_q == 3'd0) may_close = 1'b1;
    else if (tl_q >= 3'd3 && head_q == 24'h2D2D21)
      may_close = (tl_q >= 3'd5) && (prev_q == 16'h2D2D);
    else if (head_q[7:0] == 8'h3F) may_close = (prev_q[7:0] == 8'h3F);
    unique case (gs_q)
      G_LEAD, G_IGNORE:       ck = K_IGNORED;
      G_NAME, G_ATTR_SEP:     ck = K_START;
      G_ENAME, G_END_TAIL:    ck = K_END;
      G_SLASH_TAIL:           ck = K_EMPTY;
      default:                ck = K_ERROR;
    endcase
    mode_d = mode_q; gs_d = gs_q; oq_d = oq_q; vq_d = vq_q; tl_d = tl_q;
    head_d = head_q; prev_d = prev_q; ac_d = ac_q; cs_d = cs_q;
    off_d = off_q + OFFSET_BITS'(1);
    kv = 1'b0; k = K_CONTENT; tb = 1'b0;
    e = '0;
    if (mode_q == MODE_CONTENT) begin
      if (data_i == 8'h3C) begin
        mode_d = MODE_TAG; oq_d = '0; tl_d = '0; head_d = '0; prev_d = '0;
        gs_d = G_LEAD; vq_d = '0; ac_d = '0;
      end else begin
        if (!sp) cs_d = 1'b1;
        if (!sp || cs_q) kv = 1'b1;
        k = K_CONTENT;
      end
    end else if (mode_q == MODE_TAG) begin
      if (qt) begin
        if (oq_q == 8'd0) oq_d = data_i;
        else if (oq_q == data_i) oq_d = '0;
        tb = 1'b1;
      end else if (data_i == 8'h3E && may_close) begin
        kv = 1'b1; k = ck;
        if (ck == K_ERROR) mode_d = MODE_HALT;
        else begin
          mode_d = MODE_CONTENT; cs_d = 1'b0; oq_d = '0;
        end
      end else tb = 1'b1;
    end
    if (tb) begin
      if (tl_q == 3'd0) head_d[7:0] = data_i;
      if (tl_q == 3'd1) head_d[15:8] = data_i;
      if (tl_q == 3'd2) head_d[23:16] = data_i;
      prev_d = {prev_q[7:0], data_i};
      if (tl_q != 3'd7) tl_d = tl_q + 3'd1;
      unique case (gs_q)
        G_LEAD, G_SLASH_SP: begin
          if (sp) ;
          else if (data_i == 8'h3F || data_i == 8'h21) gs_d = G_IGNORE;
          else if (data_i == 8'h2F) gs_d = (gs_q == G_LEAD) ? G_SLASH_SP : G_ERROR;
          else if (data_i == 8'h3D) gs_d = G_ERROR;
          else begin
            gs_d = (gs_q == G_LEAD) ? G_NAME : G_ENAME; kv = 1'b1; k = K_ELEM;
          end
        end
        G_NAME: begin
          if (sp) gs_d = G_ATTR_SEP;
          else if (data_i == 8'h2F) gs_d = G_SLASH_TAIL;
          else if (data_i == 8'h3D) gs_d = G_ERROR;
          else begin kv = 1'b1; k = K_ELEM; end
        end
        G_ENAME: begin
          if (sp) gs_d = G_END_TAIL;
          else if (data_i == 8'h2F || data_i == 8'h3D) gs_d = G_ERROR;
          else begin kv = 1'b1; k = K_ELEM; end
        end
        G_END_TAIL, G_SLASH_TAIL: if (!sp) gs_d = G_ERROR;
        G_ATTR_SEP: begin
          if (sp) ;
          else if (data_i == 8'h2F) gs_d = G_SLASH_TAIL;
          else if (ac_q >= AW'(MAX_ATTRS) || data_i == 8'h3D) gs_d = G_ERROR;
          else begin gs_d = G_ANAME; kv = 1'b1; k = K_ATTR; end
        end
        G_ANAME: begin
          if (sp) gs_d = G_AEQ;
          else if (data_i == 8'h3D) gs_d = G_AVAL_SP;
          else if (data_i == 8'h2F) gs_d = G_ERROR;
          else begin kv = 1'b1; k = K_ATTR; end
        end
        G_AEQ: if (!sp) gs_d = (data_i == 8'h3D) ? G_AVAL_SP : G_ERROR;
        G_AVAL_SP: begin
          if (sp) ;
          else if (qt) begin vq_d = data_i; gs_d = G_AVAL; end
          else gs_d = G_ERROR;
        end
        G_AVAL: begin
          if (data_i == vq_q) begin ac_d = ac_q + AW'(1); gs_d = G_ATTR_SEP; end
          else begin kv = 1'b1; k = K_VALUE; end
        end
        G_IGNORE: ;
        default: gs_d = G_ERROR;
      endcase
    end
    if (mode_q == MODE_HALT || mode_q == mode_e'(2'd3)) begin
      kv = 1'b0; off_d = off_q; mode_d = mode_q;
    end
    e.v0 = kv; e.k0 = k;
    if (last_i && mode_d != MODE_HALT && (mode_q == MODE_CONTENT || mode_q == MODE_TAG)) begin
      e.v1 = 1'b1; e.k1 = (mode_d == MODE_CONTENT) ? K_DOC_OK : K_ERROR;
      mode_d = MODE_HALT;
    end
  end

  assign evt_o   = e;
  assign evt_v_o = take_i && (e.v0 || e.v1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CONTENT; gs_q <= G_LEAD; oq_q <= '0; vq_q <= '0; tl_q <= '0;
      head_q <= '0; prev_q <= '0; ac_q <= '0; cs_q <= 1'b0; off_q <= '0;
    end else if (take_i) begin
      mode_q <= mode_d; gs_q <= gs_d; oq_q <= oq_d; vq_q <= vq_d; tl_q <= tl_d;
      head_q <= head_d; prev_q <= prev_d; ac_q <= ac_d; cs_q <= cs_d; off_q <= off_d;
    end
  end
endmodule

@@ rtl/xtt_queue.sv @@
// ----------------------------------------------------------------------------
// xtt_queue
// small fifo of classified words between scanner and emitter
// ----------------------------------------------------------------------------
module xtt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xtt_pkg::evt_t data_i,
  output logic          space_o,
  input  logic          pop_i,
  output logic          avail_o,
  output xtt_pkg::evt_t data_o
);
  import xtt_pkg::*;
  evt_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  assign space_o = cnt_q != 3'd4;
  assign avail_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rp_q];
  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end
endmodule

@@ rtl/xtt_back.sv @@
// ----------------------------------------------------------------------------
// xtt_back
// emitter: sends one or two events per queued word into the output register
// ----------------------------------------------------------------------------
module xtt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  xtt_pkg::evt_t data_i,
  output logic          pop_o,
  output logic          tvalid_o,
  input  logic          tready_i,
  output logic [3:0]    kind_o
);
  import xtt_pkg::*;
  logic half_q, vld_q;
  logic [3:0] kind_q;
  logic load, two, first_sent;
  assign load = avail_i && (!vld_q || tready_i);
  assign two  = data_i.v0 && data_i.v1;
  assign first_sent = !data_i.v0 || half_q;
  assign pop_o = load && (!two || half_q);
  assign tvalid_o = vld_q;
  assign kind_o = kind_q;
  always_ff @(posedge clk_i) if (load) kind_q <= first_sent ? data_i.k1 : data_i.k0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; half_q <= 1'b0;
    end else begin
      if (load) vld_q <= 1'b1;
      else if (tready_i) vld_q <= 1'b0;
      if (load) half_q <= two && !half_q;
    end
  end
endmodule

@@ rtl/xml_tag_stream_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// xml_tag_stream_tokenizer_core
// streaming xml tokenizer: labels bytes and reports tag events
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata[7:0] data_byte, tlast is_last
// m_axis   out  tdata[3:0] event_kind
// one byte per cycle accepted while the 4-word queue has room
// a byte with two events leaves the queue only after the emitter has sent both
// reset returns to content mode and empties the queue
// output stalls back up through the queue into s_axis_tready
`include "xml_tag_stream_tokenizer_core_defines.svh"
module xml_tag_stream_tokenizer_core #(
  parameter int MAX_ATTRS   = 256,
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // event_kind, zero pad
);
  import xtt_pkg::*;
  evt_t fe, qe;
  logic take, push, space, avail, pop;
  logic [3:0] kind;
  assign s_axis_tready = space;
  assign take = s_axis_tvalid && space;
  xtt_front #(.MAX_ATTRS(MAX_ATTRS), .OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .take_i(take), .data_i(s_axis_tdata), .last_i(s_axis_tlast),
    .evt_o(fe), .evt_v_o(push));
  xtt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fe), .space_o(space),
    .pop_i(pop), .avail_o(avail), .data_o(qe));
  xtt_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .data_i(qe), .pop_o(pop),
    .tvalid_o(m_axis_tvalid), .tready_i(m_axis_tready), .kind_o(kind));
  assign m_axis_tdata = {4'd0, kind};

  `XTT_ASSERT(a_no_push_full, push |-> space, "push into full queue")
  `XTT_ASSERT(a_pop_avail, pop |-> avail, "pop from empty queue")
  `XTT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "output changed")
endmodule

@@ test/tb_xml_tag_stream_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_xml_tag_stream_tokenizer_core
// self-checking bench: streams one xml document of well-formed and malformed tags, comments,
// processing instructions and content with random bytes, predicts every event
// and checks the output stream in order under varying back-pressure
// ----------------------------------------------------------------------------
module tb_xml_tag_stream_tokenizer_core;
  import xtt_pkg::*;

  localparam int         NUM_ITEMS  = 950;
  localparam int         ATTR_LIMIT = 256;
  localparam int         WD_LIMIT   = 5000;
  localparam logic [3:0] K_NONE     = 4'hf;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;

  xml_tag_stream_tokenizer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  class tag_event_scoreboard;
    mode_e       mode;
    logic [7:0]  open_q;
    int          tlen;
    logic [23:0] head;
    logic [15:0] prev2;
    gram_e       gs;
    logic [7:0]  vq;
    int          nattr;
    bit          seen;
    logic [3:0]  event_q[$];
    int          errors;
    int          kind_cnt[16];

    function void clear();
      mode = MODE_CONTENT; open_q = 0; tlen = 0; head = 0; prev2 = 0;
      gs = G_LEAD; vq = 0; nattr = 0; seen = 0; errors = 0;
      foreach (kind_cnt[i]) kind_cnt[i] = 0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit quote(logic [7:0] c);
      return c == "\"" || c == "'";
    endfunction

    function logic [3:0] grammar(logic [7:0] c);
      bit sp;
      sp = blank(c);
      case (gs)
        G_LEAD, G_SLASH_SP: begin
          if (sp) return K_NONE;
          if (c == "?" || c == "!") begin gs = G_IGNORE; return K_NONE; end
          if (c == "/") begin
            gs = (gs == G_LEAD) ? G_SLASH_SP : G_ERROR;
            return K_NONE;
          end
          if (c == "=") begin gs = G_ERROR; return K_NONE; end
          gs = (gs == G_LEAD) ? G_NAME : G_ENAME;
          return K_ELEM;
        end
        G_NAME: begin
          if (sp) begin gs = G_ATTR_SEP; return K_NONE; end
          if (c == "/") begin gs = G_SLASH_TAIL; return K_NONE; end
          if (c == "=") begin gs = G_ERROR; return K_NONE; end
          return K_ELEM;
        end
        G_ENAME: begin
          if (sp) begin gs = G_END_TAIL; return K_NONE; end
          if (c == "/" || c == "=") begin gs = G_ERROR; return K_NONE; end
          return K_ELEM;
        end
        G_END_TAIL, G_SLASH_TAIL: begin
          if (!sp) gs = G_ERROR;
          return K_NONE;
        end
        G_ATTR_SEP: begin
          if (sp) return K_NONE;
          if (c == "/") begin gs = G_SLASH_TAIL; return K_NONE; end
          if (nattr >= ATTR_LIMIT || c == "=") begin gs = G_ERROR; return K_NONE; end
          gs = G_ANAME;
          return K_ATTR;
        end
        G_ANAME: begin
          if (sp) begin gs = G_AEQ; return K_NONE; end
          if (c == "=") begin gs = G_AVAL_SP; return K_NONE; end
          if (c == "/") begin gs = G_ERROR; return K_NONE; end
          return K_ATTR;
        end
        G_AEQ: begin
          if (sp) return K_NONE;
          gs = (c == "=") ? G_AVAL_SP : G_ERROR;
          return K_NONE;
        end
        G_AVAL_SP: begin
          if (sp) return K_NONE;
          if (quote(c)) begin vq = c; gs = G_AVAL; end
          else gs = G_ERROR;
          return K_NONE;
        end
        G_AVAL: begin
          if (c == vq) begin nattr++; gs = G_ATTR_SEP; return K_NONE; end
          return K_VALUE;
        end
        G_IGNORE: return K_NONE;
        default: begin gs = G_ERROR; return K_NONE; end
      endcase
    endfunction

    function logic [3:0] tag_char(logic [7:0] c);
      if (tlen < 3) head = head | (24'(c) << (8 * tlen));
      prev2 = {prev2[7:0], c};
      if (tlen < 7) tlen++;
      return grammar(c);
    endfunction

    function bit may_close();
      if (open_q != 0) return 0;
      if (tlen == 0) return 1;
      if (tlen >= 3 && head == {8'h2d, 8'h2d, 8'h21})
        return tlen >= 5 && prev2 == 16'h2d2d;
      if (head[7:0] == "?") return prev2[7:0] == "?";
      return 1;
    endfunction

    function logic [3:0] close_kind();
      case (gs)
        G_LEAD, G_IGNORE:     return K_IGNORED;
        G_NAME, G_ATTR_SEP:   return K_START;
        G_ENAME, G_END_TAIL:  return K_END;
        G_SLASH_TAIL:         return K_EMPTY;
        default:              return K_ERROR;
      endcase
    endfunction

    function void push(logic [3:0] k);
      event_q.push_back(k);
      kind_cnt[k]++;
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      logic [3:0] k;
      k = K_NONE;
      if (mode != MODE_CONTENT && mode != MODE_TAG) return;
      if (mode == MODE_CONTENT) begin
        if (c == "<") begin
          mode = MODE_TAG; open_q = 0; tlen = 0; head = 0; prev2 = 0;
          gs = G_LEAD; vq = 0; nattr = 0;
        end else begin
          if (!blank(c)) seen = 1;
          if (seen) k = K_CONTENT;
        end
      end else if (quote(c)) begin
        if (open_q == 0) open_q = c;
        else if (open_q == c) open_q = 0;
        k = tag_char(c);
      end else if (c == ">" && may_close()) begin
        k = close_kind();
        if (k == K_ERROR) mode = MODE_HALT;
        else begin
          mode = MODE_CONTENT; seen = 0; open_q = 0;
        end
      end else begin
        k = tag_char(c);
      end
      if (k != K_NONE) push(k);
      if (last && mode != MODE_HALT) begin
        push((mode == MODE_CONTENT) ? K_DOC_OK : K_ERROR);
        mode = MODE_HALT;
      end
    endfunction

    function void check_event(logic [3:0] got);
      logic [3:0] want;
      if (event_q.size() == 0) begin
        $error("event_kind: unexpected word, actual %0d", got);
        errors++;
        return;
      end
      want = event_q.pop_front();
      if (got !== want) begin
        $error("event_kind: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  tag_event_scoreboard sb;
  int n_sent;
  int phase;
  int idle_cnt;
  bit acc_s, acc_m;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitors and receiver stalls
  always @(posedge clk_i) begin
    acc_s = rst_ni && s_axis_tvalid && s_axis_tready;
    acc_m = rst_ni && m_axis_tvalid && m_axis_tready;
    if (acc_s) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (acc_m) sb.check_event(m_axis_tdata[3:0]);
    if (rst_ni) begin
      if (phase == 2) m_axis_tready <= ($urandom_range(0, 99) >= 66);
      else if (phase == 3) m_axis_tready <= ($urandom_range(0, 99) >= 9);
      else m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || acc_s || acc_m) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(input logic [7:0] b, input logic last = 1'b0);
    int pct;
    pct = (phase == 1) ? 66 : (phase == 3) ? 9 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    n_sent++;
    phase = (n_sent * 4) / NUM_ITEMS;
    if (phase > 3) phase = 3;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return 8'd32;
      1: return 8'd9;
      2: return 8'd10;
      3: return 8'd11;
      4: return 8'd12;
      default: return 8'd13;
    endcase
  endfunction

  function automatic logic [7:0] pick_name();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (sb.blank(c) || sb.quote(c) || c == "/" || c == "=" || c == ">"
           || c == "?" || c == "!");
    return c;
  endfunction

  function automatic logic [7:0] pick_other(input logic [7:0] x0, input logic [7:0] x1,
                                            input logic [7:0] x2);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == x0 || c == x1 || c == x2);
    return c;
  endfunction

  task automatic send_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) send(pick_blank());
  endtask

  task automatic send_name();
    repeat ($urandom_range(1, 4)) send(pick_name());
  endtask

  task automatic send_content();
    send_blanks(0, 2);
    repeat ($urandom_range(0, 6)) send(pick_other("<", "<", "<"));
  endtask

  task automatic send_start(input bit empty);
    logic [7:0] q;
    send("<");
    send_blanks(0, 1);
    send_name();
    repeat ($urandom_range(0, 3)) begin
      send_blanks(1, 2);
      send_name();
      send_blanks(0, 1);
      send("=");
      send_blanks(0, 1);
      q = $urandom_range(0, 1) ? "\"" : "'";
      send(q);
      repeat ($urandom_range(0, 5)) send(pick_other(q, q, q));
      send(q);
    end
    send_blanks(0, 1);
    if (empty) begin
      send("/");
      send_blanks(0, 1);
    end
    send(">");
  endtask

  task automatic send_end();
    send("<");
    send_blanks(0, 1);
    send("/");
    send_blanks(0, 1);
    send_name();
    send_blanks(0, 1);
    send(">");
  endtask

  task automatic send_comment();
    send_str("<!--");
    repeat ($urandom_range(0, 6)) send(pick_other("-", "\"", "'"));
    send_str("-->");
  endtask

  task automatic send_pi();
    send_str("<?");
    repeat ($urandom_range(0, 6)) send(pick_other("?", "\"", "'"));
    send_str("?>");
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.event_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int    ending;
    bit    paused;
    sb = new();
    sb.clear();
    n_sent = 0;
    phase = 0;
    idle_cnt = 0;
    paused = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, blank and ignored tags, quotes in odd places
    send_str(" \t>x");
    send(8'hff);
    send(8'h00);
    send_str("<>< >");
    send("<");
    send(8'h80);
    send(8'hff);
    send_str(" b='<>\"'/>");
    send_str("<!-- '>' -->");
    send_str("</ a >");

    while (n_sent < NUM_ITEMS) begin
      if (!paused && n_sent > NUM_ITEMS / 2) begin
        wait_drained();
        paused = 1;
      end
      case ($urandom_range(0, 9))
        0, 1:    send_content();
        2, 3:    send_start(1'b0);
        4:       send_start(1'b1);
        5, 6:    send_end();
        7:       send_comment();
        8:       send_pi();
        default: send_str("<!x y>");
      endcase
    end

    ending = $urandom_range(0, 2);
    if (ending == 0) begin
      send(pick_other("<", "<", "<"), 1'b1);
    end else if (ending == 1) begin
      send_str("<a=>");
      send_str("zz<q");
      send(8'h41, 1'b1);
    end else begin
      send_str("<ab");
      send(8'h63, 1'b1);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (sb.event_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d bytes: content %0d, name %0d, attr %0d, value %0d",
             n_sent, sb.kind_cnt[K_CONTENT], sb.kind_cnt[K_ELEM],
             sb.kind_cnt[K_ATTR], sb.kind_cnt[K_VALUE]);
    $display("tags: start %0d, end %0d, empty %0d, ignored %0d, error %0d, doc ok %0d",
             sb.kind_cnt[K_START], sb.kind_cnt[K_END], sb.kind_cnt[K_EMPTY],
             sb.kind_cnt[K_IGNORED], sb.kind_cnt[K_ERROR], sb.kind_cnt[K_DOC_OK]);
    if (sb.errors == 0 && sb.event_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/xtt_pkg.sv
rtl/xtt_front.sv
rtl/xtt_queue.sv
rtl/xtt_back.sv
rtl/xml_tag_stream_tokenizer_core.sv
test/tb_xml_tag_stream_tokenizer_core.sv
